### rtl/tccw_pkg.sv
// ----------------------------------------------------------------------------
// tccw_pkg: shared types and constants for the text console char writer
// Field widths, control codes, configuration indexes and the tab stop table.
// ----------------------------------------------------------------------------
package tccw_pkg;

  localparam int COL_W      = 7;
  localparam int ROW_W      = 5;
  localparam int CHAR_W     = 8;
  localparam int COLOR_W    = 4;
  localparam int CELL_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 7;
  // row * width + column never needs more than this many bits
  localparam int PROD_W     = ROW_W + COL_W + 1;

  localparam int DEF_MAX_COLUMNS = 80;
  localparam int DEF_MAX_ROWS    = 25;
  localparam int DEF_TAB_STEP    = 8;

  localparam logic [COL_W-1:0]   RST_COLUMNS = 7'd80;
  localparam logic [ROW_W-1:0]   RST_ROWS    = 5'd25;
  localparam logic [COLOR_W-1:0] RST_FG      = 4'd7;
  localparam logic [COLOR_W-1:0] RST_BG      = 4'd0;
  localparam logic               RST_NL_RET  = 1'b1;

  localparam logic [CELL_W-1:0] BLANK_RESET = 16'h0720;
  localparam logic [CHAR_W-1:0] CHAR_SPACE  = 8'h20;

  localparam logic [CHAR_W-1:0] CH_BEL = 8'h07;
  localparam logic [CHAR_W-1:0] CH_BS  = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF  = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_VT  = 8'h0B;
  localparam logic [CHAR_W-1:0] CH_FF  = 8'h0C;
  localparam logic [CHAR_W-1:0] CH_CR  = 8'h0D;

  typedef enum logic {
    CMD_PUT  = 1'b0,
    CMD_READ = 1'b1
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COLUMNS = 3'd0,
    CFG_ROWS    = 3'd1,
    CFG_FG      = 3'd2,
    CFG_BG      = 3'd3,
    CFG_NL_RET  = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } ram_ctl_t;

  // next tab stop for every possible cursor column
  localparam int TAB_IDX_N = 1 << COL_W;
  typedef logic [COL_W:0] tab_tbl_t [TAB_IDX_N];

  function automatic tab_tbl_t tab_table(input int step);
    tab_tbl_t tbl;
    int       nxt;
    nxt = step;
    for (int x = 0; x < TAB_IDX_N; x++) begin
      if (x == nxt) nxt = nxt + step;
      tbl[x] = (COL_W + 1)'(nxt);
    end
    return tbl;
  endfunction

endpackage

### rtl/tccw_cell_ram.sv
// ----------------------------------------------------------------------------
// tccw_cell_ram: screen cell store
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tccw_cell_ram #(
  parameter int DEPTH  = tccw_pkg::DEF_MAX_COLUMNS * tccw_pkg::DEF_MAX_ROWS,
  parameter int ADDR_W = 11
) (
  input  logic                        clk,
  input  tccw_pkg::ram_ctl_t          ctl_i,
  input  logic [ADDR_W-1:0]           wr_addr_i,
  input  logic [tccw_pkg::CELL_W-1:0] wr_data_i,
  input  logic [ADDR_W-1:0]           rd_addr_i,
  output logic [tccw_pkg::CELL_W-1:0] rd_data_o
);
  import tccw_pkg::*;

  logic [CELL_W-1:0] mem [DEPTH];
  logic [CELL_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (ctl_i.wr_en) mem[wr_addr_i] <= wr_data_i;
    if (ctl_i.rd_en) rd_data_r <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_r;

endmodule

### rtl/tccw_addr_unit.sv
// ----------------------------------------------------------------------------
// tccw_addr_unit: shared multiply-add unit
// Registers row * width + column; serves cell addresses and screen size.
// ----------------------------------------------------------------------------
module tccw_addr_unit #(
  parameter int CNT_W = 11
) (
  input  logic                       clk,
  input  logic [tccw_pkg::ROW_W-1:0] row_i,
  input  logic [tccw_pkg::COL_W-1:0] col_i,
  input  logic [tccw_pkg::COL_W-1:0] width_i,
  output logic [CNT_W-1:0]           result_o
);
  import tccw_pkg::*;

  logic [PROD_W-1:0] sum;
  logic [CNT_W-1:0]  result_r;

  assign sum = PROD_W'(row_i) * PROD_W'(width_i) + PROD_W'(col_i);

  always_ff @(posedge clk) begin
    result_r <= CNT_W'(sum);
  end

  assign result_o = result_r;

endmodule

### rtl/text_console_char_writer_unit.sv
// ----------------------------------------------------------------------------
// text_console_char_writer_unit: text-mode console engine
// Interprets put bytes against a cell store and cursor; reads back cells.
// ----------------------------------------------------------------------------
//
//   channel | direction | ports                                   | flow
//   --------+-----------+-----------------------------------------+-----------
//   in_     | to block  | command, char_code, read_column/_row    | valid/stall
//   out_    | from block| cursor_column, cursor_row, cell_value   | valid/stall
//   cfg_    | to block  | wr_en, index, wr_data                   | write only
//
// A scroll and a form feed sweep the cell store through its single write port.
// After reset the store is swept to blank, one cell a cycle; in_stall stays high
// then. One item is worked on at a time; a finished result waits in the output
// register while the next item is accepted.
// ----------------------------------------------------------------------------
module text_console_char_writer_unit #(
  parameter int MAX_COLUMNS = tccw_pkg::DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = tccw_pkg::DEF_MAX_ROWS,
  parameter int TAB_STEP    = tccw_pkg::DEF_TAB_STEP
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_command,
  input  logic [tccw_pkg::CHAR_W-1:0]     in_char_code,
  input  logic [tccw_pkg::COL_W-1:0]      in_read_column,
  input  logic [tccw_pkg::ROW_W-1:0]      in_read_row,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [tccw_pkg::COL_W-1:0]      out_cursor_column,
  output logic [tccw_pkg::ROW_W-1:0]      out_cursor_row,
  output logic [tccw_pkg::CELL_W-1:0]     out_cell_value,
  // configuration
  input  logic                            cfg_wr_en,
  input  logic [tccw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tccw_pkg::CFG_DATA_W-1:0] cfg_wr_data
);
  import tccw_pkg::*;

  localparam int DEPTH  = MAX_COLUMNS * MAX_ROWS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam tab_tbl_t TAB_NEXT = tab_table(TAB_STEP);

  typedef enum logic [2:0] {
    S_INIT,    // reset sweep of the cell store
    S_IDLE,
    S_EXEC,    // act on the byte or issue the read
    S_RDATA,
    S_SCROLL,  // move rows up one
    S_BLANK,   // blank the last row
    S_CLEAR,   // form feed
    S_DONE
  } state_t;

  state_t             state_r;

  // configuration registers
  logic [COL_W-1:0]   cols_r;
  logic [ROW_W-1:0]   rows_r;
  logic [COLOR_W-1:0] fg_r;
  logic [COLOR_W-1:0] bg_r;
  logic               nl_ret_r;

  // item and cursor
  cmd_t               cmd_r;
  logic [CHAR_W-1:0]  ch_r;
  logic [COL_W-1:0]   rc_r;
  logic [ROW_W-1:0]   rr_r;
  logic [COL_W-1:0]   cursor_x_r;
  logic [ROW_W-1:0]   cursor_y_r;
  logic [CELL_W-1:0]  cell_r;

  // sweep pointers
  logic [CNT_W-1:0]   src_r;
  logic [CNT_W-1:0]   dst_r;
  logic               pend_r;

  // output register
  logic               out_valid_r;
  logic [COL_W-1:0]   out_col_r;
  logic [ROW_W-1:0]   out_row_r;
  logic [CELL_W-1:0]  out_cell_r;

  logic [COL_W-1:0]   w_use;
  logic [ROW_W-1:0]   h_use;
  logic [COL_W-1:0]   sat_cx;
  logic [ROW_W-1:0]   sat_cy;
  logic [ROW_W-1:0]   unit_row;
  logic [COL_W-1:0]   unit_col;
  logic [CNT_W-1:0]   addr_q;
  logic [CELL_W-1:0]  blank;
  logic               out_free;
  logic               out_load;
  logic               rd_ok;
  logic               src_lt;
  logic               last_dst;

  // byte interpretation
  logic [COL_W:0]     tab_stop;
  logic [COL_W:0]     nx;
  logic [ROW_W:0]     ny;
  logic               ex_write;
  logic               ex_clear;
  logic               ex_scroll;
  logic [CELL_W-1:0]  ex_wdata;

  // cell store ports
  ram_ctl_t           ram_ctl;
  logic [ADDR_W-1:0]  ram_wr_addr;
  logic [CELL_W-1:0]  ram_wr_data;
  logic [ADDR_W-1:0]  ram_rd_addr;
  logic [CELL_W-1:0]  ram_rd_data;

  // Clamp the dimensions: zero acts as one, oversize as the maximum.
  always_comb begin
    w_use = cols_r;
    if (cols_r == '0) w_use = COL_W'(1);
    if (int'(cols_r) > MAX_COLUMNS) w_use = COL_W'(MAX_COLUMNS);
    h_use = rows_r;
    if (rows_r == '0) h_use = ROW_W'(1);
    if (int'(rows_r) > MAX_ROWS) h_use = ROW_W'(MAX_ROWS);
  end

  // Pull the cursor back inside the screen if the dimensions shrank.
  assign sat_cx = (cursor_x_r >= w_use) ? w_use - COL_W'(1) : cursor_x_r;
  assign sat_cy = (cursor_y_r >= h_use) ? h_use - ROW_W'(1) : cursor_y_r;

  assign blank    = {bg_r, fg_r, CHAR_SPACE};
  assign out_free = !out_valid_r || !out_stall;
  assign rd_ok    = (rc_r < w_use) && (rr_r < h_use);
  assign src_lt   = src_r < addr_q;
  assign last_dst = dst_r == addr_q - CNT_W'(1);

  // A new result enters the output register this cycle.
  assign out_load = out_free &&
                    ((state_r == S_DONE) ||
                     ((state_r == S_EXEC) && (cmd_r == CMD_PUT) &&
                      !ex_clear && !ex_scroll));

  // Shared multiply-add: in idle it forms the address of the incoming item,
  // otherwise the cell count of the screen, which the sweeps use as a bound.
  always_comb begin
    unit_row = h_use;
    unit_col = '0;
    if (state_r == S_IDLE) begin
      if (cmd_t'(in_command) == CMD_READ) begin
        unit_row = in_read_row;
        unit_col = in_read_column;
      end else begin
        unit_row = sat_cy;
        unit_col = (in_char_code == CH_BS) ? sat_cx - COL_W'(1) : sat_cx;
      end
    end
  end

  tccw_addr_unit #(
    .CNT_W (CNT_W)
  ) u_addr (
    .clk      (clk),
    .row_i    (unit_row),
    .col_i    (unit_col),
    .width_i  (w_use),
    .result_o (addr_q)
  );

  // Interpret the put byte against the cursor latched at accept.
  assign tab_stop = TAB_NEXT[cursor_x_r];

  always_comb begin
    nx       = {1'b0, cursor_x_r};
    ny       = {1'b0, cursor_y_r};
    ex_write = 1'b0;
    ex_clear = 1'b0;
    ex_wdata = blank;
    unique case (ch_r)
      CH_BEL, CH_VT: begin
      end
      CH_BS: begin
        if (cursor_x_r != '0) begin
          nx       = nx - (COL_W + 1)'(1);
          ex_write = 1'b1;
        end
      end
      CH_TAB: begin
        if (tab_stop < {1'b0, w_use}) nx = tab_stop;
      end
      CH_LF: begin
        if (nl_ret_r) nx = '0;
        ny = ny + (ROW_W + 1)'(1);
      end
      CH_FF: begin
        ex_clear = 1'b1;
        nx       = '0;
        ny       = '0;
      end
      CH_CR: begin
        nx = '0;
      end
      default: begin
        ex_write = 1'b1;
        ex_wdata = {bg_r, fg_r, ch_r};
        nx       = nx + (COL_W + 1)'(1);
      end
    endcase
    // wrap at the width, scroll at the height
    if (nx >= {1'b0, w_use}) begin
      nx = '0;
      ny = ny + (ROW_W + 1)'(1);
    end
    ex_scroll = ny >= {1'b0, h_use};
    if (ex_scroll) ny = {1'b0, h_use - ROW_W'(1)};
  end

  // Cell store port steering.
  always_comb begin
    ram_ctl     = '0;
    ram_wr_addr = dst_r[ADDR_W-1:0];
    ram_wr_data = blank;
    ram_rd_addr = src_r[ADDR_W-1:0];
    unique case (state_r)
      S_INIT: begin
        ram_ctl.wr_en = 1'b1;
        ram_wr_data   = BLANK_RESET;
      end
      S_EXEC: begin
        if (cmd_r == CMD_PUT) begin
          ram_ctl.wr_en = ex_write;
          ram_wr_addr   = addr_q[ADDR_W-1:0];
          ram_wr_data   = ex_wdata;
        end else begin
          ram_ctl.rd_en = rd_ok;
          ram_rd_addr   = addr_q[ADDR_W-1:0];
        end
      end
      S_SCROLL: begin
        // read one row ahead and write the registered read data back
        ram_ctl.rd_en = src_lt;
        ram_ctl.wr_en = pend_r;
        ram_wr_data   = ram_rd_data;
      end
      S_BLANK, S_CLEAR: begin
        ram_ctl.wr_en = 1'b1;
      end
      default: begin
      end
    endcase
  end

  tccw_cell_ram #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk       (clk),
    .ctl_i     (ram_ctl),
    .wr_addr_i (ram_wr_addr),
    .wr_data_i (ram_wr_data),
    .rd_addr_i (ram_rd_addr),
    .rd_data_o (ram_rd_data)
  );

  // Sequencer, configuration and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      cols_r      <= RST_COLUMNS;
      rows_r      <= RST_ROWS;
      fg_r        <= RST_FG;
      bg_r        <= RST_BG;
      nl_ret_r    <= RST_NL_RET;
      cursor_x_r  <= '0;
      cursor_y_r  <= '0;
      dst_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_COLUMNS: cols_r   <= cfg_wr_data[COL_W-1:0];
          CFG_ROWS:    rows_r   <= cfg_wr_data[ROW_W-1:0];
          CFG_FG:      fg_r     <= cfg_wr_data[COLOR_W-1:0];
          CFG_BG:      bg_r     <= cfg_wr_data[COLOR_W-1:0];
          CFG_NL_RET:  nl_ret_r <= cfg_wr_data[0];
          default: begin
          end
        endcase
      end

      // drop the held result once taken, unless a new one loads below
      if (out_valid_r && !out_stall && !out_load) out_valid_r <= 1'b0;

      unique case (state_r)
        S_INIT: begin
          dst_r <= dst_r + CNT_W'(1);
          if (dst_r == CNT_W'(DEPTH - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            cmd_r      <= cmd_t'(in_command);
            ch_r       <= in_char_code;
            rc_r       <= in_read_column;
            rr_r       <= in_read_row;
            cursor_x_r <= sat_cx;
            cursor_y_r <= sat_cy;
            state_r    <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (cmd_r == CMD_READ) begin
            state_r <= S_RDATA;
          end else begin
            cursor_x_r <= nx[COL_W-1:0];
            cursor_y_r <= ny[ROW_W-1:0];
            cell_r     <= '0;
            src_r      <= CNT_W'(w_use);
            dst_r      <= '0;
            pend_r     <= 1'b0;
            if (ex_clear) begin
              state_r <= S_CLEAR;
            end else if (ex_scroll) begin
              state_r <= S_SCROLL;
            end else if (out_free) begin
              // plain byte: hand the result straight to the output
              out_valid_r <= 1'b1;
              out_col_r   <= nx[COL_W-1:0];
              out_row_r   <= ny[ROW_W-1:0];
              out_cell_r  <= '0;
              state_r     <= S_IDLE;
            end else begin
              state_r <= S_DONE;
            end
          end
        end
        S_RDATA: begin
          cell_r  <= rd_ok ? ram_rd_data : '0;
          state_r <= S_DONE;
        end
        S_SCROLL: begin
          if (src_lt) src_r <= src_r + CNT_W'(1);
          pend_r <= src_lt;
          if (pend_r) dst_r <= dst_r + CNT_W'(1);
          // copies drained: dst_r now sits at the start of the last row
          if (!src_lt && !pend_r) state_r <= S_BLANK;
        end
        S_BLANK, S_CLEAR: begin
          dst_r <= dst_r + CNT_W'(1);
          if (last_dst) state_r <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_col_r   <= cursor_x_r;
            out_row_r   <= cursor_y_r;
            out_cell_r  <= cell_r;
            state_r     <= S_IDLE;
          end
        end
      endcase
    end
  end

  assign in_stall          = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_cursor_column = out_col_r;
  assign out_cursor_row    = out_row_r;
  assign out_cell_value    = out_cell_r;

endmodule

### rtl/tccw_checker.sv
// ----------------------------------------------------------------------------
// tccw_checker: port-level checks for the text console char writer
// Watches the top level ports; attached by the bind at the end of this file.
// ----------------------------------------------------------------------------
module tccw_checker #(
  parameter int MAX_COLUMNS = tccw_pkg::DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = tccw_pkg::DEF_MAX_ROWS
) (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [tccw_pkg::COL_W-1:0]      out_cursor_column,
  input logic [tccw_pkg::ROW_W-1:0]      out_cursor_row,
  input logic [tccw_pkg::CELL_W-1:0]     out_cell_value
);
  import tccw_pkg::*;

  // the block works on one item at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("item accepted while another is in progress");

  // the reset sweep holds off input right after reset
  a_init_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> in_stall)
    else $error("input taken during the reset sweep");

  // a reported cursor always lies on the largest screen
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (int'(out_cursor_column) < MAX_COLUMNS) &&
                  (int'(out_cursor_row) < MAX_ROWS))
    else $error("cursor outside the screen");

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_cursor_column) &&
                               $stable(out_cursor_row) && $stable(out_cell_value))
    else $error("stalled result changed");

endmodule

bind text_console_char_writer_unit tccw_checker #(
  .MAX_COLUMNS (MAX_COLUMNS),
  .MAX_ROWS    (MAX_ROWS)
) u_tccw_checker (.*);

### tb/sv/text_console_char_writer_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// text_console_char_writer_unit_tb: self-checking bench for the console engine
// Drives put and read items over random idle and stall, keeps its own model
// of the cell store, cursor and screen registers, and checks every result.
// ----------------------------------------------------------------------------
module text_console_char_writer_unit_tb;
  import tccw_pkg::*;

  localparam int CELL_COUNT    = DEF_MAX_COLUMNS * DEF_MAX_ROWS;
  localparam int RANDOM_ITEMS  = 1550;
  localparam int SETTLE_CYCLES = 16;

  // screen shapes used by the random phases
  typedef enum int {
    SHAPE_SMALL,
    SHAPE_EMPTY,
    SHAPE_WIDE,
    SHAPE_TALL,
    SHAPE_FULL
  } screen_shape_t;

  // one result item: cursor after the item and the cell read back
  typedef struct packed {
    logic [COL_W-1:0]  column;
    logic [ROW_W-1:0]  row;
    logic [CELL_W-1:0] cell_value;
  } console_out_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_command = 1'b0;
  logic [CHAR_W-1:0]     in_char_code = '0;
  logic [COL_W-1:0]      in_read_column = '0;
  logic [ROW_W-1:0]      in_read_row = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [COL_W-1:0]      out_cursor_column;
  logic [ROW_W-1:0]      out_cursor_row;
  logic [CELL_W-1:0]     out_cell_value;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wr_data = '0;

  // model copy of the screen registers, cell store and cursor
  logic [COL_W-1:0]   columns_reg = RST_COLUMNS;
  logic [ROW_W-1:0]   rows_reg    = RST_ROWS;
  logic [COLOR_W-1:0] fg_reg      = RST_FG;
  logic [COLOR_W-1:0] bg_reg      = RST_BG;
  logic               nl_ret_reg  = RST_NL_RET;
  logic [CELL_W-1:0]  screen_mem [CELL_COUNT];
  int                 cur_x = 0;
  int                 cur_y = 0;

  console_out_t expected_console_out [$];
  console_out_t want;
  int           error_count = 0;
  bit           idle_on = 1'b1;
  bit           out_fire = 1'b0;
  int           hold_left = 0;
  longint       cycle_count = 0;
  longint       cycle_limit = 20000;

  text_console_char_writer_unit DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_command        (in_command),
    .in_char_code      (in_char_code),
    .in_read_column    (in_read_column),
    .in_read_row       (in_read_row),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_cursor_column (out_cursor_column),
    .out_cursor_row    (out_cursor_row),
    .out_cell_value    (out_cell_value),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wr_data       (cfg_wr_data)
  );

  always #4 clk = ~clk;

  // --------------------------------------------------------------------------
  // Model helpers
  // --------------------------------------------------------------------------

  // A zero dimension acts as one, an oversized one as the maximum.
  function automatic int columns_in_use();
    int c;
    c = int'(columns_reg);
    if (c == 0) c = 1;
    if (c > DEF_MAX_COLUMNS) c = DEF_MAX_COLUMNS;
    return c;
  endfunction

  function automatic int rows_in_use();
    int r;
    r = int'(rows_reg);
    if (r == 0) r = 1;
    if (r > DEF_MAX_ROWS) r = DEF_MAX_ROWS;
    return r;
  endfunction

  // Work out the result of one accepted item and advance the model state.
  // The store is laid out row by row with the pitch of the current width.
  function automatic console_out_t predict_console(cmd_t cmd, logic [CHAR_W-1:0] ch,
                                                   logic [COL_W-1:0] rc,
                                                   logic [ROW_W-1:0] rr);
    console_out_t      res;
    int                w;
    int                h;
    int                x;
    bit                found;
    logic [CELL_W-1:0] blank;
    w = columns_in_use();
    h = rows_in_use();
    blank = {bg_reg, fg_reg, CHAR_SPACE};
    res.cell_value = '0;
    // pull a cursor left outside by a shrink back onto the screen
    if (cur_x >= w) cur_x = w - 1;
    if (cur_y >= h) cur_y = h - 1;
    if (cmd == CMD_PUT) begin
      case (ch)
        CH_BEL, CH_VT: ;
        CH_BS: begin
          if (cur_x > 0) begin
            cur_x--;
            screen_mem[w * cur_y + cur_x] = blank;
          end
        end
        CH_TAB: begin
          // stay put when no stop lies right of the cursor inside the width
          found = 1'b0;
          for (x = cur_x + 1; x < w && !found; x++) begin
            if (x % DEF_TAB_STEP == 0) begin
              cur_x = x;
              found = 1'b1;
            end
          end
        end
        CH_LF: begin
          if (nl_ret_reg) cur_x = 0;
          cur_y++;
        end
        CH_FF: begin
          for (x = 0; x < w * h; x++) screen_mem[x] = blank;
          cur_x = 0;
          cur_y = 0;
        end
        CH_CR: cur_x = 0;
        default: begin
          screen_mem[w * cur_y + cur_x] = {bg_reg, fg_reg, ch};
          cur_x++;
        end
      endcase
      if (cur_x >= w) begin
        cur_x = 0;
        cur_y++;
      end
      if (cur_y >= h) begin
        // scroll up one row and blank the bottom row
        for (x = 0; x + w < w * h; x++) screen_mem[x] = screen_mem[x + w];
        for (x = (h - 1) * w; x < w * h; x++) screen_mem[x] = blank;
        cur_y = h - 1;
      end
    end else if (int'(rc) < w && int'(rr) < h) begin
      res.cell_value = screen_mem[int'(rr) * w + int'(rc)];
    end
    res.column = COL_W'(cur_x);
    res.row    = ROW_W'(cur_y);
    return res;
  endfunction

  function automatic int idle_draw();
    return idle_on ? int'($urandom_range(0, 3)) : 0;
  endfunction

  function automatic logic [COLOR_W-1:0] pick_nibble();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      default: return COLOR_W'($urandom_range(0, 15));
    endcase
  endfunction

  function automatic logic [CHAR_W-1:0] control_code(int k);
    case (k)
      0:       return CH_BEL;
      1:       return CH_BS;
      2:       return CH_TAB;
      3:       return CH_LF;
      4:       return CH_VT;
      5:       return CH_FF;
      default: return CH_CR;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Item and register traffic
  // --------------------------------------------------------------------------

  // Send one item after a random gap; predict it at the accepting edge.
  // Drop valid behind the accepted item so no stalled payload ever changes.
  task automatic send_console_item(cmd_t cmd, logic [CHAR_W-1:0] ch,
                                   logic [COL_W-1:0] rc, logic [ROW_W-1:0] rr);
    int gap;
    gap = idle_draw();
    // budget a scroll or clear on every item, with room for both idlers
    cycle_limit += 4 * (columns_in_use() * rows_in_use() + 16);
    repeat (gap + 1) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid       <= 1'b1;
    in_command     <= cmd;
    in_char_code   <= ch;
    in_read_column <= rc;
    in_read_row    <= rr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_console_out.push_back(predict_console(cmd, ch, rc, rr));
  endtask

  // Unused fields of an item carry random bits so every input bit toggles.
  task automatic put_char(logic [CHAR_W-1:0] ch);
    send_console_item(CMD_PUT, ch, COL_W'($urandom()), ROW_W'($urandom()));
  endtask

  task automatic read_cell(logic [COL_W-1:0] rc, logic [ROW_W-1:0] rr);
    send_console_item(CMD_READ, CHAR_W'($urandom()), rc, rr);
  endtask

  // Drop valid and wait until every result is back and the block is quiet.
  task automatic settle_console();
    cycle_limit += 4 * SETTLE_CYCLES + 64;
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_console_out.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= idx;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    case (idx)
      CFG_COLUMNS: columns_reg = value[COL_W-1:0];
      CFG_ROWS:    rows_reg    = value[ROW_W-1:0];
      CFG_FG:      fg_reg      = value[COLOR_W-1:0];
      CFG_BG:      bg_reg      = value[COLOR_W-1:0];
      CFG_NL_RET:  nl_ret_reg  = value[0];
      default: ;
    endcase
  endtask

  // Reprogram the whole screen setup once the block has gone idle.
  task automatic apply_screen(logic [COL_W-1:0] cols, logic [ROW_W-1:0] rows,
                              logic [COLOR_W-1:0] fg, logic [COLOR_W-1:0] bg,
                              logic nl_ret);
    settle_console();
    write_register(CFG_COLUMNS, CFG_DATA_W'(cols));
    write_register(CFG_ROWS, CFG_DATA_W'(rows));
    write_register(CFG_FG, CFG_DATA_W'(fg));
    write_register(CFG_BG, CFG_DATA_W'(bg));
    write_register(CFG_NL_RET, CFG_DATA_W'(nl_ret));
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset contents: blank cells inside the screen, zero just outside it.
  task automatic test_reset_contents();
    read_cell('0, '0);
    read_cell(COL_W'(DEF_MAX_COLUMNS - 1), ROW_W'(DEF_MAX_ROWS - 1));
    read_cell(COL_W'(DEF_MAX_COLUMNS), '0);
    read_cell('0, ROW_W'(DEF_MAX_ROWS));
    read_cell('1, '1);
  endtask

  // Every control byte plus the extreme printable codes on the reset screen.
  task automatic test_put_controls();
    put_char(8'h41);
    put_char(8'hFF);
    put_char(8'h00);
    put_char(CH_BEL);
    put_char(CH_VT);
    put_char(CH_BS);
    put_char(CH_TAB);
    put_char(CH_CR);
    put_char(CH_BS);     // backspace at column zero does nothing
    put_char(CH_LF);
    put_char(CH_FF);
    read_cell('0, '0);
  endtask

  // Zero, shrunk and oversized dimensions; tab with no stop; plain newline.
  task automatic test_dimension_edges();
    apply_screen('0, '0, RST_FG, RST_BG, RST_NL_RET);
    put_char(8'h78);     // one-cell screen: write, wrap and scroll at once
    read_cell('0, '0);
    apply_screen(7'd10, 5'd3, 4'hF, 4'hF, 1'b0);
    put_char(8'h61);
    put_char(CH_TAB);
    put_char(CH_TAB);    // no stop left inside ten columns
    put_char(CH_LF);     // newline without return keeps the column
    apply_screen(7'd4, 5'd1, 4'hF, 4'hF, 1'b0);
    put_char(CH_BEL);    // cursor saturates onto the shrunk screen
    apply_screen('1, '1, 4'h0, 4'hF, 1'b1);
    read_cell(COL_W'(DEF_MAX_COLUMNS - 1), ROW_W'(DEF_MAX_ROWS - 1));
    put_char(8'h7E);
  endtask

  // Random phases, each with its own screen setup and idle mode.
  task automatic test_random_traffic();
    int            sent;
    int            phase;
    int            count;
    int            i;
    int            r;
    int            w;
    int            h;
    screen_shape_t shape;
    logic [COL_W-1:0] cols;
    logic [ROW_W-1:0] rows;
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      // open with one full screen and one degenerate one, then mostly small
      r = $urandom_range(0, 15);
      if (phase == 0)      shape = SHAPE_FULL;
      else if (phase == 1) shape = SHAPE_EMPTY;
      else if (r == 0)     shape = SHAPE_FULL;
      else if (r == 1)     shape = SHAPE_EMPTY;
      else if (r < 4)      shape = SHAPE_WIDE;
      else if (r < 6)      shape = SHAPE_TALL;
      else                 shape = SHAPE_SMALL;
      case (shape)
        SHAPE_FULL: begin
          cols = COL_W'($urandom_range(DEF_MAX_COLUMNS, 127));
          rows = ROW_W'($urandom_range(DEF_MAX_ROWS, 31));
        end
        SHAPE_EMPTY: begin
          cols = ($urandom_range(0, 1) != 0) ? '0 : COL_W'($urandom_range(1, 12));
          rows = (cols != 0 || $urandom_range(0, 1) != 0) ? '0 :
                 ROW_W'($urandom_range(1, 6));
        end
        SHAPE_WIDE: begin
          cols = COL_W'($urandom_range(17, DEF_MAX_COLUMNS));
          rows = ROW_W'($urandom_range(1, 3));
        end
        SHAPE_TALL: begin
          cols = COL_W'($urandom_range(1, 4));
          rows = ROW_W'($urandom_range(7, DEF_MAX_ROWS));
        end
        default: begin
          cols = COL_W'($urandom_range(1, 16));
          rows = ROW_W'($urandom_range(1, 6));
        end
      endcase
      idle_on = ($urandom_range(0, 3) != 0);
      apply_screen(cols, rows, pick_nibble(), pick_nibble(), 1'($urandom()));
      w = columns_in_use();
      h = rows_in_use();
      if (shape == SHAPE_FULL) begin
        // run off the bottom once so the full-size scroll is exercised
        count = 40;
        for (i = 0; i <= h; i++) put_char(CH_LF);
        sent += h + 1;
      end else begin
        count = $urandom_range(40, 80);
      end
      for (i = 0; i < count; i++) begin
        r = $urandom_range(0, 99);
        if (r < 55)      put_char(CHAR_W'($urandom()));
        else if (r < 72) put_char(control_code($urandom_range(0, 6)));
        else if (r < 92) read_cell(COL_W'($urandom_range(0, w - 1)),
                                   ROW_W'($urandom_range(0, h - 1)));
        else             read_cell(COL_W'($urandom()), ROW_W'($urandom()));
      end
      sent += count;
      phase++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side: stall at random after each result, check at the rising edge
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (out_fire) hold_left = idle_draw();
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    out_fire = 1'b0;
    if (rst_n && out_valid && !out_stall) begin
      out_fire = 1'b1;
      if (expected_console_out.size() == 0) begin
        $error("result with no item outstanding: column %0d row %0d cell %h",
               out_cursor_column, out_cursor_row, out_cell_value);
        error_count++;
      end else begin
        want = expected_console_out.pop_front();
        if (out_cursor_column !== want.column) begin
          $error("cursor_column mismatch: expected %0d, actual %0d",
                 want.column, out_cursor_column);
          error_count++;
        end
        if (out_cursor_row !== want.row) begin
          $error("cursor_row mismatch: expected %0d, actual %0d",
                 want.row, out_cursor_row);
          error_count++;
        end
        if (out_cell_value !== want.cell_value) begin
          $error("cell_value mismatch: expected %h, actual %h",
                 want.cell_value, out_cell_value);
          error_count++;
        end
      end
    end
  end

  // Watchdog: the budget grows with every item sent, so a hang trips it.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > cycle_limit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    for (int i = 0; i < CELL_COUNT; i++) screen_mem[i] = BLANK_RESET;
    // hold reset, then release; the block sweeps its store before taking items
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    test_reset_contents();
    test_put_controls();
    test_dimension_edges();
    test_random_traffic();
    settle_console();
    if (error_count == 0 && expected_console_out.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
